// ===== rtl/core/psw_pkg.sv =====
// Shared types, constants and helper functions for the periodic stencil weight generator.
// No dependencies; imported by psw_row_pipe, periodic_stencil_weight_gen, psw_checker and tb.
`default_nettype none

package psw_pkg;

	localparam int LANES = 5;

	// configuration register indexes
	localparam logic [2:0] CFG_SIZE_X     = 3'd0;
	localparam logic [2:0] CFG_SIZE_Y     = 3'd1;
	localparam logic [2:0] CFG_SIZE_Z     = 3'd2;
	localparam logic [2:0] CFG_HALF_WIDTH = 3'd3;
	localparam logic [2:0] CFG_WEIGHTS_ON = 3'd4;

	// one row request from the sequencer
	typedef struct packed {
		logic                   last;
		logic [8:0]             zt;
		logic [8:0]             yt;
		logic [LANES-1:0][8:0]  xt;
		logic [LANES-1:0]       en;
		logic [LANES-1:0][3:0]  d2;
	} row_cmd_t;

	// one finished row
	typedef struct packed {
		logic                   last;
		logic [LANES-1:0][23:0] idx;
		logic [LANES-1:0][15:0] wt;
	} row_out_t;

	// four steps of restoring remainder, one dividend bit per step
	function automatic logic [8:0] mod_step4(input logic [8:0] rem, input logic [3:0] bits,
			input logic [8:0] n);
		logic [8:0] r;
		logic [9:0] t;
		r = rem;
		for (int i = 3; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, n}) begin
				t = t - {1'b0, n};
			end
			r = t[8:0];
		end
		return r;
	endfunction

	// r < n, off in -2..2: true periodic wrap of r + off
	function automatic logic [8:0] wrap(input logic [8:0] r, input logic signed [2:0] off,
			input logic [8:0] n);
		logic signed [10:0] v;
		logic signed [10:0] nn;
		logic [8:0]         res;
		v  = signed'({2'b00, r}) + 11'(off);
		nn = signed'({2'b00, n});
		if (n == 9'd1) begin
			res = '0;
		end else if (v < 0) begin
			res = 9'(v + nn);
		end else if (v >= nn) begin
			res = 9'(v - nn);
		end else begin
			res = 9'(v);
		end
		return res;
	endfunction

	function automatic logic [3:0] sq(input logic signed [2:0] off);
		logic [3:0] s;
		case (off)
			3'sd0:          s = 4'd0;
			3'sd1, -3'sd1:  s = 4'd1;
			3'sd2, -3'sd2:  s = 4'd4;
			3'sd3, -3'sd3:  s = 4'd9;
			default:        s = 4'd0;
		endcase
		return s;
	endfunction

	// quartic B-spline weight, Q0.16, by squared distance
	function automatic logic [15:0] wt_lookup(input logic [3:0] d2);
		logic [15:0] w;
		case (d2)
			4'd0:    w = 16'd39253;
			4'd1:    w = 16'd12971;
			4'd2:    w = 16'd3795;
			4'd3:    w = 16'd950;
			4'd4:    w = 16'd171;
			4'd5:    w = 16'd13;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psw_row_pipe.sv =====
// Row datapath: registered row request, index products and weight lookup, output register.
// Depends on psw_pkg for row_cmd_t, row_out_t and wt_lookup.
`default_nettype none

module psw_row_pipe import psw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_v,
	input  wire row_cmd_t   cmd,
	input  wire logic [8:0] nx,
	input  wire logic [17:0] nxy,
	input  wire logic       weights_on,
	input  wire logic       out_stall,
	output logic            adv,
	output logic            out_v,
	output row_out_t        out
);

	logic                   v_s3, v_s4;
	row_cmd_t               cmd_s3;
	logic [23:0]            zy_s4;
	logic [17:0]            yy_s4;
	logic [LANES-1:0][8:0]  xt_s4;
	logic [LANES-1:0]       en_s4;
	logic [LANES-1:0][15:0] wt_s4;
	logic                   last_s4;
	logic [26:0]            zprod;
	logic [17:0]            yprod;
	row_out_t               res;

	// whole row pipe holds while a finished row waits
	assign adv = !out_v || !out_stall;

	assign zprod = {18'b0, cmd_s3.zt} * {9'b0, nxy};
	assign yprod = {9'b0, cmd_s3.yt} * {9'b0, nx};

	always_comb begin
		res.last = last_s4;
		for (int l = 0; l < LANES; l++) begin
			res.idx[l] = en_s4[l] ? (zy_s4 + {6'b0, yy_s4} + {15'b0, xt_s4[l]}) : '0;
			res.wt[l]  = wt_s4[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			out_v <= 1'b0;
		end else if (adv) begin
			v_s3  <= cmd_v;
			v_s4  <= v_s3;
			out_v <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3  <= cmd;
			zy_s4   <= zprod[23:0];
			yy_s4   <= yprod;
			xt_s4   <= cmd_s3.xt;
			en_s4   <= cmd_s3.en;
			last_s4 <= cmd_s3.last;
			for (int l = 0; l < LANES; l++) begin
				wt_s4[l] <= (cmd_s3.en[l] && weights_on) ? wt_lookup(cmd_s3.d2[l]) : '0;
			end
			out <= res;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s3) && $stable(v_s4))
		else $error("row pipe moved while stalled");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_v == $past(v_s4))
		else $error("row pipe valid lost or invented");

endmodule

`default_nettype wire

// ===== rtl/core/periodic_stencil_weight_gen.sv =====
// Periodic stencil weight generator: 2*hw+1 squared rows per cell, one row per output transfer.
// An accepted cell passes the two remainder stages and the row sequencer; each row then passes the row pipe registers.
// Throughput: one row per cycle while the output is not stalled; a cell occupies the row sequencer for 1, 9 or 25 rows.
// The next cell is taken in while the previous one is still being expanded.
// Reset clears all valid bits; sizes reset to 1, half width to 1, weights on.
// Depends on psw_pkg and psw_row_pipe.
`default_nettype none

module periodic_stencil_weight_gen import psw_pkg::*; #(
	parameter int MAX_DIM  = 256,
	parameter int MAX_HALF = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  cell_x,
	input  wire logic [7:0]  cell_y,
	input  wire logic [7:0]  cell_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [23:0]      index_0,
	output logic [23:0]      index_1,
	output logic [23:0]      index_2,
	output logic [23:0]      index_3,
	output logic [23:0]      index_4,
	output logic [15:0]      weight_0,
	output logic [15:0]      weight_1,
	output logic [15:0]      weight_2,
	output logic [15:0]      weight_3,
	output logic [15:0]      weight_4,
	output logic             last_row
);

	localparam logic [10:0] MaxDimW = 11'(MAX_DIM);
	localparam int          HCap    = (MAX_HALF < 2) ? MAX_HALF : 2;

	logic [8:0]  size_x_q, size_y_q, size_z_q;
	logic [1:0]  half_width_q;
	logic        weights_on_q;
	logic [8:0]  nx, ny, nz;
	logic [17:0] nxy_q;
	logic [1:0]  h;
	logic [2:0]  h2;

	logic        v_s1, v_s2, rdy_s1, rdy_s2;
	logic [8:0]  rx_s1, ry_s1, rz_s1;
	logic [3:0]  lx_s1, ly_s1, lz_s1;
	logic [8:0]  rx_s2, ry_s2, rz_s2;

	logic        seq_v_q;
	logic [2:0]  cy_q, cz_q;
	logic [8:0]  rx_q, ry_q, rz_q;
	logic        seq_last, issue, seq_load, adv;
	logic signed [2:0] dy, dz, dx;
	row_cmd_t    cmd;
	logic        row_v;
	row_out_t    row;

	function automatic logic [8:0] eff_size(input logic [8:0] s);
		logic [8:0] e;
		if (s == 9'd0) begin
			e = 9'd1;
		end else if ({2'b00, s} > MaxDimW) begin
			e = 9'(MAX_DIM);
		end else begin
			e = s;
		end
		return e;
	endfunction

	assign nx = eff_size(size_x_q);
	assign ny = eff_size(size_y_q);
	assign nz = eff_size(size_z_q);
	assign h  = ({30'b0, half_width_q} > HCap) ? 2'(HCap) : half_width_q;
	assign h2 = {h, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q     <= 9'd1;
			size_y_q     <= 9'd1;
			size_z_q     <= 9'd1;
			half_width_q <= 2'd1;
			weights_on_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE_X:     size_x_q     <= cfg_data;
				CFG_SIZE_Y:     size_y_q     <= cfg_data;
				CFG_SIZE_Z:     size_z_q     <= cfg_data;
				CFG_HALF_WIDTH: half_width_q <= cfg_data[1:0];
				CFG_WEIGHTS_ON: weights_on_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		nxy_q <= {9'b0, nx} * {9'b0, ny};
	end

	// front end: coordinate mod size, four remainder steps per stage
	assign rdy_s2   = !v_s2 || seq_load;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			rx_s1 <= mod_step4('0, cell_x[7:4], nx);
			ry_s1 <= mod_step4('0, cell_y[7:4], ny);
			rz_s1 <= mod_step4('0, cell_z[7:4], nz);
			lx_s1 <= cell_x[3:0];
			ly_s1 <= cell_y[3:0];
			lz_s1 <= cell_z[3:0];
		end
		if (rdy_s2 && v_s1) begin
			rx_s2 <= mod_step4(rx_s1, lx_s1, nx);
			ry_s2 <= mod_step4(ry_s1, ly_s1, ny);
			rz_s2 <= mod_step4(rz_s1, lz_s1, nz);
		end
	end

	// row sequencer: z outer, y inner
	assign seq_last = (cz_q == h2) && (cy_q == h2);
	assign issue    = seq_v_q && adv;
	assign seq_load = v_s2 && (!seq_v_q || (issue && seq_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q <= 1'b0;
			cy_q    <= '0;
			cz_q    <= '0;
		end else if (seq_load) begin
			seq_v_q <= 1'b1;
			cy_q    <= '0;
			cz_q    <= '0;
		end else if (issue) begin
			if (seq_last) begin
				seq_v_q <= 1'b0;
			end else if (cy_q == h2) begin
				cy_q <= '0;
				cz_q <= cz_q + 3'd1;
			end else begin
				cy_q <= cy_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_load) begin
			rx_q <= rx_s2;
			ry_q <= ry_s2;
			rz_q <= rz_s2;
		end
	end

	assign dy = 3'(cy_q - {1'b0, h});
	assign dz = 3'(cz_q - {1'b0, h});

	always_comb begin
		dx       = '0;
		cmd.last = seq_last;
		cmd.yt   = wrap(ry_q, dy, ny);
		cmd.zt   = wrap(rz_q, dz, nz);
		for (int l = 0; l < LANES; l++) begin
			dx         = 3'(3'(l) - {1'b0, h});
			cmd.en[l]  = 3'(l) <= h2;
			cmd.xt[l]  = wrap(rx_q, dx, nx);
			cmd.d2[l]  = sq(dx) + sq(dy) + sq(dz);
		end
	end

	psw_row_pipe u_rows (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_v      (seq_v_q),
		.cmd        (cmd),
		.nx         (nx),
		.nxy        (nxy_q),
		.weights_on (weights_on_q),
		.out_stall  (out_stall),
		.adv        (adv),
		.out_v      (row_v),
		.out        (row)
	);

	assign out_valid = row_v;
	assign index_0   = row.idx[0];
	assign index_1   = row.idx[1];
	assign index_2   = row.idx[2];
	assign index_3   = row.idx[3];
	assign index_4   = row.idx[4];
	assign weight_0  = row.wt[0];
	assign weight_1  = row.wt[1];
	assign weight_2  = row.wt[2];
	assign weight_3  = row.wt[3];
	assign weight_4  = row.wt[4];
	assign last_row  = row.last;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_v_q |-> (cy_q <= h2) && (cz_q <= h2))
		else $error("row counters beyond stencil width");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !seq_load |=> v_s2)
		else $error("front-end cell dropped before sequencer load");

	a_seq_done: assert property (@(posedge clk) disable iff (!arst_n)
		issue && seq_last && !v_s2 |=> !seq_v_q)
		else $error("sequencer still busy after last row");

endmodule

`default_nettype wire

// ===== tb/psw_checker.sv =====
`timescale 1ns / 100ps
// Checker for periodic_stencil_weight_gen: tracks register writes, expands each accepted cell
// into its stencil rows and compares every output transfer against the oldest expected row.
// Depends on psw_pkg (register codes, row_out_t).

module psw_checker import psw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  cell_x,
	input  logic [7:0]  cell_y,
	input  logic [7:0]  cell_z,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [23:0] index_0,
	input  logic [23:0] index_1,
	input  logic [23:0] index_2,
	input  logic [23:0] index_3,
	input  logic [23:0] index_4,
	input  logic [15:0] weight_0,
	input  logic [15:0] weight_1,
	input  logic [15:0] weight_2,
	input  logic [15:0] weight_3,
	input  logic [15:0] weight_4,
	input  logic        last_row,
	output int          fail_count,
	output int          rows_due
);

	localparam int DIM_LIMIT  = 256;
	localparam int HALF_LIMIT = 2;

	logic [8:0] size_x_q, size_y_q, size_z_q;
	logic [1:0] half_q;
	logic       weights_q;

	row_out_t   stencil_rows[$];
	row_out_t   want, got;
	int         mismatches;
	int         rows_seen;

	function automatic int grid_dim(input logic [8:0] s);
		if (s == 9'd0) return 1;
		if (int'(s) > DIM_LIMIT) return DIM_LIMIT;
		return int'(s);
	endfunction

	function automatic int wrap_coord(input int c, input int off, input int n);
		int r;
		r = (c + off) % n;
		if (r < 0) r += n;
		return r;
	endfunction

	// quartic B-spline of distance sqrt(d2), Q0.16 rounded to nearest
	function automatic logic [15:0] spline_weight(input int d2);
		real d, v;
		d = $sqrt(d2);
		if (d <= 0.5)
			v = d*d*d*d/4.0 - 5.0*d*d/8.0 + 115.0/192.0;
		else if (d <= 1.5)
			v = -d*d*d*d/6.0 + 5.0*d*d*d/6.0 - 5.0*d*d/4.0 + 5.0*d/24.0 + 55.0/96.0;
		else if (d <= 2.5)
			v = (2.5-d)*(2.5-d)*(2.5-d)*(2.5-d)/24.0;
		else
			v = 0.0;
		return 16'($rtoi(v*65536.0 + 0.5));
	endfunction

	task automatic predict_stencil(input logic [7:0] cx, input logic [7:0] cy,
			input logic [7:0] cz);
		int nx, ny, nz, h, dx, dy, dz, lane, base;
		row_out_t r;
		nx = grid_dim(size_x_q);
		ny = grid_dim(size_y_q);
		nz = grid_dim(size_z_q);
		h  = int'(half_q);
		if (h > HALF_LIMIT) h = HALF_LIMIT;
		for (dz = -h; dz <= h; dz++) begin
			for (dy = -h; dy <= h; dy++) begin
				r = '0;
				base = wrap_coord(int'(cz), dz, nz) * nx * ny + wrap_coord(int'(cy), dy, ny) * nx;
				for (lane = 0; lane < LANES; lane++) begin
					if (lane < 2*h + 1) begin
						dx = lane - h;
						r.idx[lane] = 24'(base + wrap_coord(int'(cx), dx, nx));
						if (weights_q)
							r.wt[lane] = spline_weight(dx*dx + dy*dy + dz*dz);
					end
				end
				r.last = (dz == h) && (dy == h);
				stencil_rows.push_back(r);
			end
		end
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t ns: row %0d %s expected %0d, got %0d", $time, rows_seen, name,
				want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   = 9'd1;
			size_y_q   = 9'd1;
			size_z_q   = 9'd1;
			half_q     = 2'd1;
			weights_q  = 1'b1;
			mismatches = 0;
			rows_seen  = 0;
			stencil_rows.delete();
			fail_count <= 0;
			rows_due   <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE_X:     size_x_q  = cfg_data;
					CFG_SIZE_Y:     size_y_q  = cfg_data;
					CFG_SIZE_Z:     size_z_q  = cfg_data;
					CFG_HALF_WIDTH: half_q    = cfg_data[1:0];
					CFG_WEIGHTS_ON: weights_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_stencil(cell_x, cell_y, cell_z);
			if (out_valid && !out_stall) begin
				if (stencil_rows.size() == 0) begin
					$display("%0t ns: row %0d with none expected: index_0 %0d, last_row %0b",
						$time, rows_seen, index_0, last_row);
					mismatches++;
				end else begin
					want = stencil_rows.pop_front();
					got.last = last_row;
					got.idx  = {index_4, index_3, index_2, index_1, index_0};
					got.wt   = {weight_4, weight_3, weight_2, weight_1, weight_0};
					for (int i = 0; i < LANES; i++) begin
						check_field($sformatf("index_%0d", i), int'(want.idx[i]), int'(got.idx[i]));
						check_field($sformatf("weight_%0d", i), int'(want.wt[i]), int'(got.wt[i]));
					end
					check_field("last_row", int'(want.last), int'(got.last));
				end
				rows_seen++;
			end
			fail_count <= mismatches;
			rows_due   <= stencil_rows.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the periodic_stencil_weight_gen testbench: clock, reset, register loads, cell traffic
// and output back-pressure; psw_checker does the prediction and this module gives the verdict.
// Depends on psw_pkg, psw_checker and the block itself.

module tb;
	import psw_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = CFG_SIZE_X;
	logic [8:0]  cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  cell_x    = '0;
	logic [7:0]  cell_y    = '0;
	logic [7:0]  cell_z    = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [23:0] index_0, index_1, index_2, index_3, index_4;
	logic [15:0] weight_0, weight_1, weight_2, weight_3, weight_4;
	logic        last_row;

	int          fail_count;
	int          rows_due;
	int          cycles   = 0;
	bit          hold_req = 1'b0;
	logic [8:0]  dim_x = 9'd1, dim_y = 9'd1, dim_z = 9'd1;

	periodic_stencil_weight_gen u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_z    (cell_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.index_0   (index_0),
		.index_1   (index_1),
		.index_2   (index_2),
		.index_3   (index_3),
		.index_4   (index_4),
		.weight_0  (weight_0),
		.weight_1  (weight_1),
		.weight_2  (weight_2),
		.weight_3  (weight_3),
		.weight_4  (weight_4),
		.last_row  (last_row)
	);

	psw_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_z     (cell_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.index_0    (index_0),
		.index_1    (index_1),
		.index_2    (index_2),
		.index_3    (index_3),
		.index_4    (index_4),
		.weight_0   (weight_0),
		.weight_1   (weight_1),
		.weight_2   (weight_2),
		.weight_3   (weight_3),
		.weight_4   (weight_4),
		.last_row   (last_row),
		.fail_count (fail_count),
		.rows_due   (rows_due)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("periodic_stencil_weight_gen: mismatch");
			$finish;
		end
	end

	// size register value: mostly small grids, sometimes full range, zero or oversize
	function automatic logic [8:0] rand_dim();
		case ($urandom_range(0, 9))
			0:       return 9'($urandom_range(257, 511));
			1:       return 9'd0;
			2, 3:    return 9'($urandom_range(1, 256));
			default: return 9'($urandom_range(1, 9));
		endcase
	endfunction

	// coordinate biased to the grid edges, with some lying beyond the grid
	function automatic logic [7:0] rand_coord(input logic [8:0] s);
		int n;
		n = (s == 9'd0) ? 1 : ((s > 9'd256) ? 256 : int'(s));
		case ($urandom_range(0, 5))
			0:       return 8'($urandom_range(0, 255));
			1:       return 8'd0;
			2:       return 8'(n - 1);
			default: return 8'($urandom_range(0, n - 1));
		endcase
	endfunction

	task automatic put_reg(input logic [2:0] idx, input logic [8:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [8:0] sx, input logic [8:0] sy, input logic [8:0] sz,
			input logic [1:0] hw, input logic wo);
		put_reg(CFG_SIZE_X, sx);
		put_reg(CFG_SIZE_Y, sy);
		put_reg(CFG_SIZE_Z, sz);
		put_reg(CFG_HALF_WIDTH, {7'd0, hw});
		put_reg(CFG_WEIGHTS_ON, {8'd0, wo});
		cfg_we <= 1'b0;
		dim_x = sx;
		dim_y = sy;
		dim_z = sz;
	endtask

	// offer one cell after a random gap and return once the transfer has happened
	task automatic send_cell(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
		int r, gap;
		r = $urandom_range(0, 19);
		gap = (r < 10) ? 0 : ((r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 30));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_x   <= x;
		cell_y   <= y;
		cell_z   <= z;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, wait for every expected row, then cover the pipeline latency
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (rows_due != 0);
		repeat (8) @(posedge clk);
	endtask

	// receiver: alternating free runs and stalls, plus one long hold on request
	initial begin
		int r, len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 19);
			len = (r < 12) ? $urandom_range(1, 4) : $urandom_range(10, 60);
			out_stall <= 1'b0;
			repeat (len) @(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				len = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 19);
				len = (r < 16) ? $urandom_range(1, 3) : $urandom_range(8, 25);
			end
			out_stall <= 1'b1;
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: 1x1x1 grid, half width 1, weights on
		send_cell(8'd0, 8'd0, 8'd0);
		send_cell(8'd255, 8'd255, 8'd255);
		send_cell(8'd7, 8'd0, 8'd128);
		settle();

		// largest grid, widest stencil, corners wrapping both ways
		load_config(9'd256, 9'd256, 9'd256, 2'd2, 1'b1);
		send_cell(8'd0, 8'd0, 8'd0);
		send_cell(8'd255, 8'd255, 8'd255);
		send_cell(8'd0, 8'd255, 8'd1);
		send_cell(8'd128, 8'd64, 8'd254);
		settle();

		// zero size, oversize, half width above the limit
		load_config(9'd0, 9'd511, 9'd300, 2'd3, 1'b1);
		send_cell(8'd5, 8'd255, 8'd200);
		send_cell(8'd0, 8'd1, 8'd255);
		settle();

		// single-lane rows with weights off, coordinates beyond the grid
		load_config(9'd3, 9'd1, 9'd7, 2'd0, 1'b0);
		send_cell(8'd2, 8'd0, 8'd6);
		send_cell(8'd3, 8'd9, 8'd7);
		send_cell(8'd170, 8'd85, 8'd0);
		settle();

		load_config(9'd5, 9'd4, 9'd2, 2'd1, 1'b0);
		send_cell(8'd4, 8'd3, 8'd1);
		send_cell(8'd0, 8'd0, 8'd0);
		send_cell(8'd200, 8'd100, 8'd50);
		settle();

		// writes past the register list must leave the setting above untouched
		for (int k = 1; k <= 3; k++)
			put_reg(CFG_WEIGHTS_ON + 3'(k), 9'h1FF);
		cfg_we <= 1'b0;
		send_cell(8'd1, 8'd1, 8'd1);
		send_cell(8'd4, 8'd0, 8'd0);
		settle();

		for (int p = 0; p < 6; p++) begin
			load_config(rand_dim(), rand_dim(), rand_dim(),
				(p == 2) ? 2'd2 : 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			// one phase runs against a long output hold so the block backs up
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < 20; i++)
				send_cell(rand_coord(dim_x), rand_coord(dim_y), rand_coord(dim_z));
			settle();
		end

		@(negedge clk);
		if (fail_count == 0 && rows_due == 0)
			$display("periodic_stencil_weight_gen: match");
		else
			$display("periodic_stencil_weight_gen: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/psw_pkg.sv
rtl/core/psw_row_pipe.sv
rtl/core/periodic_stencil_weight_gen.sv
tb/psw_checker.sv
tb/tb.sv
